// ----- hdl/rcp_pkg.sv -----
// Shared types and constants for the RC pulse to bidirectional PWM block.
package rcp_pkg;

  // Direction confirmation: confidence runs 0 .. 2*ConfirmPulses, centre at ConfirmPulses
  localparam int unsigned ConfirmPulses = 3;
  localparam int unsigned ConfTop       = 2 * ConfirmPulses;
  localparam int unsigned ConfBits      = $clog2(ConfTop + 1);

  // Pulse width counter
  localparam int unsigned CountBits = 12;
  localparam int unsigned CountMax  = (1 << CountBits) - 1;

  // Register widths
  localparam int unsigned NeutralBits = 12;
  localparam int unsigned DeadBits    = 8;
  localparam int unsigned CfgDataBits = 12;
  localparam int unsigned CfgIdxBits  = 1;

  // Width used for compare and subtract of widths against the dead-band edges
  localparam int unsigned SumBits = ((CountBits > NeutralBits) ? CountBits : NeutralBits) + 1;

  // Duty output
  localparam int unsigned DutyBits = 8;
  localparam int unsigned DutySpan = 255;

  // Width queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegNeutral = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegDead    = 1'd1;

  typedef logic [CountBits-1:0] width_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // One result item
  typedef struct packed {
    logic [DutyBits-1:0] duty;
    logic                fwd;
    logic                bwd;
    logic                drive;
  } res_t;

endpackage

// ----- hdl/rc_pulse_to_bidirectional_pwm.sv -----
// Top level of the RC pulse to bidirectional PWM block.
//
//   Channel  Direction  Handshake                Payload
//   in       to block   in_valid_i / in_stall_o  pulse_level_i
//   out      from block out_valid_o / out_stall_i duty_o, forward_enable_o,
//                                                backward_enable_o, drive_active_o
//   cfg      to block   cfg_we_i                 cfg_index_i, cfg_data_i
//
// One line sample is taken per cycle while the input is not stalled; the sample that shows a
// falling edge queues the width, and with the queue empty and the output free the result
// item goes from the width queue straight into the output register.
// The two-entry width queue sets when the input stalls: only when it is full.
// Reset (rst_ni low, asynchronous) empties the queue and output register,
// clears the width counter and centres direction confidence.
module rc_pulse_to_bidirectional_pwm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [rcp_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pulse_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcp_pkg::DutyBits-1:0]    duty_o,
  output logic                            forward_enable_o,
  output logic                            backward_enable_o,
  output logic                            drive_active_o
);

  rcp_pkg::q_status_t q_status;
  rcp_pkg::width_t    push_width, head_width;
  logic               push, pop;
  rcp_pkg::res_t      res;

  // Edge detection and width measurement
  rcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pulse_level_i(pulse_level_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_width_o (push_width)
  );

  // Width queue
  rcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_width_i(push_width),
    .pop_i       (pop),
    .head_width_o(head_width),
    .status_o    (q_status)
  );

  // Classification and drive decision
  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .head_width_i(head_width),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign duty_o            = res.duty;
  assign forward_enable_o  = res.fwd;
  assign backward_enable_o = res.bwd;
  assign drive_active_o    = res.drive;

endmodule

// ----- hdl/rcp_front.sv -----
// Front end: samples the pulse line, measures high time, queues widths on falling edges.
module rcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            pulse_level_i,
  input  rcp_pkg::q_status_t q_status_i,
  output logic            push_o,
  output rcp_pkg::width_t push_width_o
);

  rcp_pkg::width_t width_q, width_d;
  logic            prev_q, prev_d;
  logic            accept;

  // Hold the line off while the queue has no room
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  // Width counter with saturation, edge detect
  always_comb begin
    width_d = width_q;
    prev_d  = prev_q;
    push_o  = 1'b0;
    if (accept) begin
      if (pulse_level_i) begin
        if (!prev_q) begin
          width_d = rcp_pkg::width_t'(1);
        end else if (width_q != rcp_pkg::width_t'(rcp_pkg::CountMax)) begin
          width_d = width_q + rcp_pkg::width_t'(1);
        end
        prev_d = 1'b1;
      end else begin
        if (prev_q) begin
          push_o = 1'b1;
        end
        prev_d = 1'b0;
      end
    end
  end

  assign push_width_o = width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
      prev_q  <= 1'b0;
    end else begin
      width_q <= width_d;
      prev_q  <= prev_d;
    end
  end

endmodule

// ----- hdl/rcp_queue.sv -----
// Short queue of measured pulse widths between front and back.
module rcp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rcp_pkg::width_t    push_width_i,
  input  logic               pop_i,
  output rcp_pkg::width_t    head_width_o,
  output rcp_pkg::q_status_t status_o
);

  rcp_pkg::width_t                   mem_q [rcp_pkg::QueueDepth];
  logic [rcp_pkg::QPtrBits-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [rcp_pkg::QCntBits-1:0]      cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == rcp_pkg::QCntBits'(rcp_pkg::QueueDepth));
  assign status_o.valid = (cnt_q != '0);
  assign head_width_o   = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == rcp_pkg::QPtrBits'(rcp_pkg::QueueDepth - 1)) ? '0
             : wr_q + rcp_pkg::QPtrBits'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == rcp_pkg::QPtrBits'(rcp_pkg::QueueDepth - 1)) ? '0
             : rd_q + rcp_pkg::QPtrBits'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + rcp_pkg::QCntBits'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - rcp_pkg::QCntBits'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/rcp_back.sv -----
// Back end: classifies queued widths, tracks direction confidence, registers result items.
module rcp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [rcp_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  rcp_pkg::q_status_t               q_status_i,
  input  rcp_pkg::width_t                  head_width_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rcp_pkg::res_t                    res_o
);

  localparam int unsigned SB = rcp_pkg::SumBits;

  logic [rcp_pkg::NeutralBits-1:0] neutral_q;
  logic [rcp_pkg::DeadBits-1:0]    dead_q;
  logic [rcp_pkg::ConfBits-1:0]    conf_q, conf_d;
  logic                            vld_q;
  rcp_pkg::res_t                   res_q, res_d;

  logic [SB-1:0] w, nt, db, upper, lower, d_fwd, d_bwd;
  logic          is_fwd, is_bwd, lower_ok;

  // Take the next width when the output register is free or being emptied
  assign pop_o = q_status_i.valid && (!vld_q || !out_stall_i);

  // Dead-band edges
  assign w        = SB'(head_width_i);
  assign nt       = SB'(neutral_q);
  assign db       = SB'(dead_q);
  assign upper    = nt + db;
  assign lower_ok = (nt >= db);
  assign lower    = nt - db;
  assign is_fwd   = (w > upper);
  assign is_bwd   = lower_ok && (w < lower);
  assign d_fwd    = w - upper;
  assign d_bwd    = lower - w;

  // Classification and confidence stepping
  always_comb begin
    conf_d    = conf_q;
    res_d     = '0;
    if (is_fwd) begin
      if (conf_q == rcp_pkg::ConfBits'(rcp_pkg::ConfTop)) begin
        res_d.duty  = (d_fwd > SB'(rcp_pkg::DutySpan)) ? rcp_pkg::DutyBits'(rcp_pkg::DutySpan)
                      : d_fwd[rcp_pkg::DutyBits-1:0];
        res_d.fwd   = 1'b1;
        res_d.drive = 1'b1;
      end else begin
        conf_d = conf_q + rcp_pkg::ConfBits'(1);
      end
    end else if (is_bwd) begin
      if (conf_q == '0) begin
        res_d.duty  = (d_bwd > SB'(rcp_pkg::DutySpan)) ? rcp_pkg::DutyBits'(rcp_pkg::DutySpan)
                      : d_bwd[rcp_pkg::DutyBits-1:0];
        res_d.bwd   = 1'b1;
        res_d.drive = 1'b1;
      end else begin
        conf_d = conf_q - rcp_pkg::ConfBits'(1);
      end
    end else begin
      // Neutral pulse pulls confidence back to centre
      if (conf_q > rcp_pkg::ConfBits'(rcp_pkg::ConfirmPulses)) begin
        conf_d = conf_q - rcp_pkg::ConfBits'(1);
      end else if (conf_q < rcp_pkg::ConfBits'(rcp_pkg::ConfirmPulses)) begin
        conf_d = conf_q + rcp_pkg::ConfBits'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= rcp_pkg::NeutralBits'(663);
      dead_q    <= rcp_pkg::DeadBits'(5);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcp_pkg::RegNeutral: neutral_q <= cfg_data_i[rcp_pkg::NeutralBits-1:0];
        rcp_pkg::RegDead:    dead_q    <= cfg_data_i[rcp_pkg::DeadBits-1:0];
        default: ;
      endcase
    end
  end

  // Confidence and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= rcp_pkg::ConfBits'(rcp_pkg::ConfirmPulses);
      vld_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        conf_q <= conf_d;
        vld_q  <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q  <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ----- tb/tb_rc_pulse_to_bidirectional_pwm.sv -----
// Self-checking testbench for the RC pulse to bidirectional PWM block.
module tb_rc_pulse_to_bidirectional_pwm;
  timeunit 1ns;
  timeprecision 1ps;

  // One directed pulse: register setting, high width, and the result if known up front
  typedef struct packed {
    logic [11:0]   nt;
    logic [7:0]    db;
    logic [12:0]   width;
    logic          typed;
    rcp_pkg::res_t res;
  } plan_row_t;

  localparam plan_row_t Plan [22] = '{
    // reset setting: exact neutral, then one just above the band
    {12'd663,  8'd5,   13'd663,  1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd663,  8'd5,   13'd669,  1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    // build forward confidence, then drive
    {12'd20,   8'd2,   13'd30,   1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd30,   1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd30,   1'b1, 8'd8,   1'b1, 1'b0, 1'b1},
    {12'd20,   8'd2,   13'd23,   1'b1, 8'd1,   1'b1, 1'b0, 1'b1},
    // band edges count as neutral
    {12'd20,   8'd2,   13'd22,   1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd18,   1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    // walk confidence down to the backward end
    {12'd20,   8'd2,   13'd17,   1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd17,   1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd1,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd1,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd20,   8'd2,   13'd1,    1'b1, 8'd17,  1'b0, 1'b1, 1'b1},
    // backward duty clamps
    {12'd4095, 8'd0,   13'd1,    1'b1, 8'd255, 1'b0, 1'b1, 1'b1},
    // lower edge below zero: shortest pulse is neutral
    {12'd0,    8'd255, 13'd1,    1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd0,    8'd0,   13'd2,    1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd0,    8'd0,   13'd2,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd0,    8'd0,   13'd2,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd0,    8'd0,   13'd2,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    {12'd0,    8'd0,   13'd2,    1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    // forward duty clamps, then a saturated width count
    {12'd0,    8'd0,   13'd300,  1'b1, 8'd255, 1'b1, 1'b0, 1'b1},
    {12'd3900, 8'd0,   13'd4200, 1'b1, 8'd195, 1'b1, 1'b0, 1'b1}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [rcp_pkg::CfgIdxBits-1:0]  cfg_index_i = rcp_pkg::RegNeutral;
  logic [rcp_pkg::CfgDataBits-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            pulse_level_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [rcp_pkg::DutyBits-1:0]    duty_o;
  logic                            forward_enable_o;
  logic                            backward_enable_o;
  logic                            drive_active_o;

  rc_pulse_to_bidirectional_pwm uut (.*);

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted block state and registers
  rcp_pkg::width_t  line_width = '0;
  logic             line_high = 1'b0;
  int               confidence = int'(rcp_pkg::ConfirmPulses);
  logic             fwd_latch = 1'b0;
  logic             bwd_latch = 1'b0;
  logic [11:0]      neutral_reg = 12'd663;
  logic [7:0]       dead_reg = 8'd5;

  rcp_pkg::res_t    due_results[$];
  logic             typed_due = 1'b0;
  rcp_pkg::res_t    typed_res = '0;
  int               errors = 0;
  int               results_made = 0;
  int               rand_items = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               stall_left = 0;
  logic             quiet = 1'b0;
  int               cur_nt = 663;
  int               cur_db = 5;

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Track one line sample; a falling edge yields the motor command
  function automatic void step_line(input logic lvl);
    int            w;
    int            upper;
    int            lower;
    int            d;
    rcp_pkg::res_t r;
    if (lvl) begin
      if (!line_high) line_width = rcp_pkg::width_t'(1);
      else if (line_width < rcp_pkg::width_t'(rcp_pkg::CountMax)) line_width++;
      line_high = 1'b1;
      return;
    end
    if (!line_high) return;
    line_high = 1'b0;
    w = int'(line_width);
    upper = int'(neutral_reg) + int'(dead_reg);
    lower = int'(neutral_reg) - int'(dead_reg);
    r = '0;
    if (w > upper) begin
      if (confidence == int'(rcp_pkg::ConfTop)) begin
        d = w - upper;
        r.duty = (d > int'(rcp_pkg::DutySpan)) ? rcp_pkg::DutyBits'(rcp_pkg::DutySpan)
                 : rcp_pkg::DutyBits'(d);
        r.drive = 1'b1;
        fwd_latch = 1'b1;
        bwd_latch = 1'b0;
      end else begin
        fwd_latch = 1'b0;
        bwd_latch = 1'b0;
        confidence++;
      end
    end else if (w < lower) begin
      if (confidence == 0) begin
        d = lower - w;
        r.duty = (d > int'(rcp_pkg::DutySpan)) ? rcp_pkg::DutyBits'(rcp_pkg::DutySpan)
                 : rcp_pkg::DutyBits'(d);
        r.drive = 1'b1;
        bwd_latch = 1'b1;
        fwd_latch = 1'b0;
      end else begin
        fwd_latch = 1'b0;
        bwd_latch = 1'b0;
        confidence--;
      end
    end else begin
      // neutral: release and drift back to centre
      fwd_latch = 1'b0;
      bwd_latch = 1'b0;
      if (confidence > int'(rcp_pkg::ConfirmPulses)) confidence--;
      else if (confidence < int'(rcp_pkg::ConfirmPulses)) confidence++;
    end
    r.fwd = fwd_latch;
    r.bwd = bwd_latch;
    results_made++;
    if (typed_due) begin
      r = typed_res;
      typed_due = 1'b0;
    end
    due_results.push_back(r);
  endfunction

  // Check results, then follow register writes and accepted items
  always @(posedge clk_i) begin
    rcp_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report("result with none due, duty", int'(duty_o), 0);
        end else begin
          want = due_results.pop_front();
          if (duty_o !== want.duty) report("duty", int'(duty_o), int'(want.duty));
          if (forward_enable_o !== want.fwd)
            report("forward_enable", int'(forward_enable_o), int'(want.fwd));
          if (backward_enable_o !== want.bwd)
            report("backward_enable", int'(backward_enable_o), int'(want.bwd));
          if (drive_active_o !== want.drive)
            report("drive_active", int'(drive_active_o), int'(want.drive));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == rcp_pkg::RegNeutral) neutral_reg = cfg_data_i[11:0];
        else if (cfg_index_i == rcp_pkg::RegDead) dead_reg = cfg_data_i[7:0];
      end
      if (in_valid_i && !in_stall_o) step_line(pulse_level_i);
    end
  end

  // Output stall in random bursts
  always @(negedge clk_i) begin
    if (quiet || stall_pct == 0) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 7);
    end
  end

  // One line sample, with an optional idle burst first
  task automatic send_item(input logic lvl);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pulse_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    rand_items++;
    @(negedge clk_i);
  endtask

  task automatic send_pulse(input int width, input int gap, input logic typed,
                            input rcp_pkg::res_t want);
    repeat (width) send_item(1'b1);
    typed_due = typed;
    typed_res = want;
    repeat (gap) send_item(1'b0);
  endtask

  // Registers change only once the block has drained
  task automatic load_regs(input int nt, input int db);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= rcp_pkg::RegNeutral;
    cfg_data_i <= rcp_pkg::CfgDataBits'(nt);
    @(negedge clk_i);
    cfg_index_i <= rcp_pkg::RegDead;
    cfg_data_i <= {4'($urandom), 8'(db)};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_nt = nt;
    cur_db = db;
  endtask

  // Stimulus
  initial begin
    plan_row_t row;
    int        nt;
    int        db;
    int        cls;
    int        run_left;
    int        w;
    int        up;
    int        lo;
    int        pick;
    int        pulses;
    int        rand_results;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pulses
    idle_pct = 20;
    stall_pct = 20;
    send_item(1'b0);
    send_item(1'b0);
    foreach (Plan[i]) begin
      row = Plan[i];
      if (int'(row.nt) != cur_nt || int'(row.db) != cur_db)
        load_regs(int'(row.nt), int'(row.db));
      send_pulse(int'(row.width), 1, row.typed, row.res);
    end

    // Random phases: runs of same-direction pulses with some noise
    rand_items = 0;
    rand_results = results_made;
    while (rand_items < 1650 || results_made < rand_results + 60) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        nt = $urandom_range(0, 8);
        db = 255;
      end else if (pick == 1) begin
        nt = $urandom_range(3840, 4095);
        db = $urandom_range(0, 255);
      end else begin
        nt = $urandom_range(4, 48);
        db = $urandom_range(0, 12);
      end
      if (rand_items >= 1400) begin
        quiet = 1'b1;
        idle_pct = 0;
      end else begin
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      load_regs(nt, db);
      up = nt + db;
      lo = nt - db;
      run_left = 0;
      cls = 3;
      pulses = $urandom_range(4, 16);
      repeat (pulses) begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 99);
          cls = (pick < 35) ? 0 : (pick < 70) ? 1 : (pick < 85) ? 2 : 3;
          run_left = $urandom_range(2, 8);
        end
        run_left--;
        w = $urandom_range(1, 80);
        if (cls == 0 && up < 600) begin
          w = up + 1 + $urandom_range(0, 40);
        end else if (cls == 1 && lo >= 2) begin
          w = (lo > 600) ? $urandom_range(1, 60)
              : $urandom_range((lo > 41) ? lo - 40 : 1, lo - 1);
        end else if (cls == 2 && up < 600 && up >= ((lo > 1) ? lo : 1)) begin
          w = $urandom_range((lo > 1) ? lo : 1, up);
        end
        send_pulse(w, $urandom_range(1, 4), 1'b0, '0);
      end
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    for (int n = 0; n < 20000 && due_results.size() != 0; n++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (due_results.size() != 0) report("results never seen, count", due_results.size(), 0);
    if (errors == 0) begin
      $display("rc_pulse_to_bidirectional_pwm regression: pass");
    end else begin
      $display("rc_pulse_to_bidirectional_pwm regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("rc_pulse_to_bidirectional_pwm regression: fail");
    $finish;
  end

endmodule
